/* src/isl_pkg.sv */
// ----------------------------------------------------------------------------
// isl_pkg: shared types and constants for the indexed shift list
// Item layouts, command and status codes, cell control bundle and
// controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package isl_pkg;

  localparam int CAPACITY  = 64;
  localparam int WORD_BITS = 32;
  localparam int CMD_W     = 3;
  localparam int IDX_W     = 6;
  localparam int DATA_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int CNT_W     = 7;

  // readout tree: groups of GRP_SIZE taps, each group ORed into a register
  localparam int GRP_SIZE  = 8;
  localparam int GRP_CNT   = CAPACITY / GRP_SIZE;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ      = 3'd0,
    CMD_APPEND    = 3'd1,
    CMD_INSERT    = 3'd2,
    CMD_REMOVE    = 3'd3,
    CMD_OVERWRITE = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_LOAD,
    OP_INSERT,
    OP_REMOVE
  } cell_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TAP,
    S_GROUP,
    S_OUT
  } isl_state_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [IDX_W-1:0]  index;
    logic [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0]   data;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    count;
  } out_item_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic                 step;
    cell_op_t             op;
    logic [CNT_W-1:0]     pos;
    logic [CNT_W-1:0]     count;
    logic [WORD_BITS-1:0] value;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_pos;
  } cell_ctl_t;

endpackage

`default_nettype wire

/* src/indexed_shift_list.sv */
// ----------------------------------------------------------------------------
// indexed_shift_list: ordered word list with insert and remove by index
// A row of cells holds the list; each command updates all cells at once.
// ----------------------------------------------------------------------------
// Each input item is one command (read, append, insert, remove, overwrite)
// and yields exactly one result item with the word read or removed, a
// status and the entry count after the command. All cells shift in parallel
// in the cycle the item is accepted; the word read or removed then passes
// through a two-level registered OR tree into the output register. The
// tap registers, the group registers and the output register fill in turn
// through the states S_TAP, S_GROUP and S_OUT; no new item is accepted
// until the result is taken, and with the result taken at once the next
// item is accepted in that same cycle. No clearing pass runs after reset:
// entries at or above the count are never returned.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_shift_list (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire isl_pkg::in_item_t in_item,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output isl_pkg::out_item_t     out_item
);

  isl_pkg::isl_state_t state_r, state_nxt;

  logic [isl_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [isl_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [isl_pkg::CNT_W-1:0]    ocount_r;
  logic [isl_pkg::DATA_W-1:0]   odata_r;

  logic                      accept;
  logic                      full;
  logic                      idx_lt;
  logic                      idx_le;
  logic [isl_pkg::CNT_W-1:0] idx_ext;
  isl_pkg::cell_ctl_t        ctl;

  logic [isl_pkg::WORD_BITS-1:0] words [isl_pkg::CAPACITY];
  logic [isl_pkg::WORD_BITS-1:0] taps  [isl_pkg::CAPACITY];
  logic [isl_pkg::WORD_BITS-1:0] tree_word;

  assign in_ready  = (state_r == isl_pkg::S_IDLE) ||
                     (state_r == isl_pkg::S_OUT && out_ready);
  assign out_valid = (state_r == isl_pkg::S_OUT);
  assign accept    = in_valid && in_ready;

  assign idx_ext = {1'b0, in_item.index};
  assign full    = (count_r == isl_pkg::CNT_W'(isl_pkg::CAPACITY));
  assign idx_lt  = idx_ext < count_r;
  assign idx_le  = idx_ext <= count_r;

  // command decode
  always_comb begin
    ctl        = '0;
    ctl.step   = accept;
    ctl.op     = isl_pkg::OP_NONE;
    ctl.pos    = idx_ext;
    ctl.count  = count_r;
    ctl.value  = in_item.value[isl_pkg::WORD_BITS-1:0];
    ctl.rd_pos = in_item.index;
    count_nxt  = count_r;
    status_nxt = isl_pkg::STAT_DONE;
    unique case (in_item.cmd)
      isl_pkg::CMD_READ: begin
        if (idx_lt) ctl.rd_en = 1'b1;
        else        status_nxt = isl_pkg::STAT_RANGE;
      end
      isl_pkg::CMD_APPEND: begin
        if (full) begin
          status_nxt = isl_pkg::STAT_FULL;
        end else begin
          ctl.op    = isl_pkg::OP_LOAD;
          ctl.pos   = count_r;
          count_nxt = count_r + isl_pkg::CNT_W'(1);
        end
      end
      isl_pkg::CMD_INSERT: begin
        if (full) begin
          status_nxt = isl_pkg::STAT_FULL;
        end else if (!idx_le) begin
          status_nxt = isl_pkg::STAT_RANGE;
        end else begin
          ctl.op    = isl_pkg::OP_INSERT;
          count_nxt = count_r + isl_pkg::CNT_W'(1);
        end
      end
      isl_pkg::CMD_REMOVE: begin
        if (idx_lt) begin
          ctl.op    = isl_pkg::OP_REMOVE;
          ctl.rd_en = 1'b1;
          count_nxt = count_r - isl_pkg::CNT_W'(1);
        end else begin
          status_nxt = isl_pkg::STAT_RANGE;
        end
      end
      isl_pkg::CMD_OVERWRITE: begin
        if (idx_lt) ctl.op = isl_pkg::OP_LOAD;
        else        status_nxt = isl_pkg::STAT_RANGE;
      end
      default: begin
        // unused codes: leave everything as is
      end
    endcase
  end

  for (genvar i = 0; i < isl_pkg::CAPACITY; i++) begin : g_cell
    logic [isl_pkg::WORD_BITS-1:0] left_w;
    logic [isl_pkg::WORD_BITS-1:0] right_w;

    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = words[i-1];
    end

    if (i == isl_pkg::CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = words[i+1];
    end

    isl_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .pos        (isl_pkg::IDX_W'(i)),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (words[i]),
      .tap        (taps[i])
    );
  end

  isl_or_tree u_tree (
    .clk    (clk),
    .taps   (taps),
    .result (tree_word)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      isl_pkg::S_IDLE:  if (accept) state_nxt = isl_pkg::S_TAP;
      isl_pkg::S_TAP:   state_nxt = isl_pkg::S_GROUP;
      isl_pkg::S_GROUP: state_nxt = isl_pkg::S_OUT;
      isl_pkg::S_OUT: begin
        if (accept)         state_nxt = isl_pkg::S_TAP;
        else if (out_ready) state_nxt = isl_pkg::S_IDLE;
      end
      default: state_nxt = isl_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= isl_pkg::S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) count_r <= count_nxt;
    end
  end

  // result payload: status and count at acceptance, word after the tree
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      ocount_r <= count_nxt;
    end
    if (state_r == isl_pkg::S_GROUP) begin
      odata_r <= isl_pkg::DATA_W'(tree_word);
    end
  end

  assign out_item.data   = odata_r;
  assign out_item.status = status_r;
  assign out_item.count  = ocount_r;

endmodule

`default_nettype wire

/* src/isl_cell.sv */
// ----------------------------------------------------------------------------
// isl_cell: one entry of the shift list
// Holds one word, takes a neighbor's word on insert or remove, loads the
// command word at its position, and captures a read tap.
// ----------------------------------------------------------------------------
`default_nettype none

module isl_cell (
  input  wire logic                          clk,
  input  wire isl_pkg::cell_ctl_t            ctl,
  input  wire logic [isl_pkg::IDX_W-1:0]     pos,
  input  wire logic [isl_pkg::WORD_BITS-1:0] left_word,
  input  wire logic [isl_pkg::WORD_BITS-1:0] right_word,
  output logic      [isl_pkg::WORD_BITS-1:0] word,
  output logic      [isl_pkg::WORD_BITS-1:0] tap
);

  logic [isl_pkg::WORD_BITS-1:0] word_r, word_nxt;
  logic [isl_pkg::WORD_BITS-1:0] tap_r, tap_nxt;
  logic [isl_pkg::CNT_W-1:0]     pos_ext;
  logic [isl_pkg::CNT_W-1:0]     pos_inc;

  assign pos_ext = {1'b0, pos};
  assign pos_inc = pos_ext + isl_pkg::CNT_W'(1);

  always_comb begin
    word_nxt = word_r;
    unique case (ctl.op)
      isl_pkg::OP_LOAD: begin
        if (pos_ext == ctl.pos) word_nxt = ctl.value;
      end
      isl_pkg::OP_INSERT: begin
        if (pos_ext == ctl.pos) begin
          word_nxt = ctl.value;
        end else if (pos_ext > ctl.pos && pos_ext <= ctl.count) begin
          word_nxt = left_word;
        end
      end
      isl_pkg::OP_REMOVE: begin
        // close the gap: every later entry moves down one place
        if (pos_ext >= ctl.pos && pos_inc < ctl.count) word_nxt = right_word;
      end
      default: word_nxt = word_r;
    endcase
  end

  // capture the addressed word before the shift lands
  assign tap_nxt = (ctl.rd_en && pos == ctl.rd_pos) ? word_r : '0;

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      word_r <= word_nxt;
      tap_r  <= tap_nxt;
    end
  end

  assign word = word_r;
  assign tap  = tap_r;

endmodule

`default_nettype wire

/* src/isl_or_tree.sv */
// ----------------------------------------------------------------------------
// isl_or_tree: readout tree over the cell taps
// At most one tap is nonzero; OR groups into registers, then OR the groups.
// ----------------------------------------------------------------------------
`default_nettype none

module isl_or_tree (
  input  wire logic                          clk,
  input  wire logic [isl_pkg::WORD_BITS-1:0] taps [isl_pkg::CAPACITY],
  output logic      [isl_pkg::WORD_BITS-1:0] result
);

  logic [isl_pkg::WORD_BITS-1:0] groups_r   [isl_pkg::GRP_CNT];
  logic [isl_pkg::WORD_BITS-1:0] groups_nxt [isl_pkg::GRP_CNT];

  always_comb begin
    for (int g = 0; g < isl_pkg::GRP_CNT; g++) begin
      groups_nxt[g] = '0;
      for (int k = 0; k < isl_pkg::GRP_SIZE; k++) begin
        groups_nxt[g] = groups_nxt[g] | taps[g * isl_pkg::GRP_SIZE + k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < isl_pkg::GRP_CNT; g++) begin
      groups_r[g] <= groups_nxt[g];
    end
  end

  always_comb begin
    result = '0;
    for (int g = 0; g < isl_pkg::GRP_CNT; g++) begin
      result = result | groups_r[g];
    end
  end

endmodule

`default_nettype wire
